@@ design/cto_pkg.sv @@
// ----------------------------------------------------------------------------
// cto_pkg: shared types and constants for the connection timeout table
// Field widths, operation codes, controller states and the command/status
// structs that join the controller and the datapath.
// ----------------------------------------------------------------------------
package cto_pkg;

  // Field widths
  localparam int MODE_W    = 2;
  localparam int SLOT_W    = 5;
  localparam int DL_W      = 32;
  localparam int TIMEOUT_W = 16;

  // Operation codes carried in the mode field
  localparam logic [MODE_W-1:0] MODE_START = 2'd0;
  localparam logic [MODE_W-1:0] MODE_STOP  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_TICK  = 2'd2;

  // Timeout register value after reset
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 16'd300;

  // Sign bit flip that turns a modular offset into an ordered key
  localparam logic [DL_W-1:0] KEY_FLIP = 32'h8000_0000;

  // Controller states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CLOSE
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic take_item;
    logic scan_en;
    logic emit_close;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic scan_done;
    logic out_free;
  } sts_t;

endpackage

@@ design/cto_ifs.sv @@
// ----------------------------------------------------------------------------
// cto_ifs: channel interfaces of the connection timeout table
// Input item channel, result channel and timeout register write channel,
// each with valid/ready and its payload.
// ----------------------------------------------------------------------------

// Input item channel
interface cto_in_if;
  logic                         valid;
  logic                         ready;
  logic [cto_pkg::MODE_W-1:0]   mode;
  logic [cto_pkg::SLOT_W-1:0]   client;

  modport source (output valid, output mode, output client, input ready);
  modport sink   (input valid, input mode, input client, output ready);
endinterface

// Result channel
interface cto_out_if;
  logic                         valid;
  logic                         ready;
  logic                         expired;
  logic [cto_pkg::SLOT_W-1:0]   expired_client;
  logic                         pending;
  logic [cto_pkg::DL_W-1:0]     next_deadline;
  logic                         last;

  modport source (output valid, output expired, output expired_client, output pending,
                  output next_deadline, output last, input ready);
  modport sink   (input valid, input expired, input expired_client, input pending,
                  input next_deadline, input last, output ready);
endinterface

// Timeout register write channel
interface cto_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [cto_pkg::TIMEOUT_W-1:0]   timeout_seconds;

  modport source (output valid, output timeout_seconds, input ready);
  modport sink   (input valid, input timeout_seconds, output ready);
endinterface

@@ design/cto_ram.sv @@
// ----------------------------------------------------------------------------
// cto_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data; the read
// data holds while the read enable is low.
// ----------------------------------------------------------------------------
module cto_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ design/cto_ctrl.sv @@
// ----------------------------------------------------------------------------
// cto_ctrl: sequencing controller of the connection timeout table
// Takes one transaction, runs the slot scan in the datapath and then
// issues the closing result before returning to idle.
// ----------------------------------------------------------------------------
module cto_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output cto_pkg::cmd_t cmd,
  input  cto_pkg::sts_t sts
);

  cto_pkg::state_t state_r;
  cto_pkg::state_t state_nxt;

  // State register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= cto_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      cto_pkg::ST_IDLE: begin
        if (in_valid) begin
          state_nxt = cto_pkg::ST_SCAN;
        end
      end
      cto_pkg::ST_SCAN: begin
        if (sts.scan_done) begin
          state_nxt = cto_pkg::ST_CLOSE;
        end
      end
      cto_pkg::ST_CLOSE: begin
        if (sts.out_free) begin
          state_nxt = cto_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = cto_pkg::ST_IDLE;
      end
    endcase
  end

  // Outputs
  always_comb begin
    in_ready       = 1'b0;
    cmd.take_item  = 1'b0;
    cmd.scan_en    = 1'b0;
    cmd.emit_close = 1'b0;
    unique case (state_r)
      cto_pkg::ST_IDLE: begin
        in_ready      = 1'b1;
        cmd.take_item = in_valid;
      end
      cto_pkg::ST_SCAN: begin
        cmd.scan_en = 1'b1;
      end
      cto_pkg::ST_CLOSE: begin
        cmd.emit_close = 1'b1;
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

endmodule

@@ design/cto_dp.sv @@
// ----------------------------------------------------------------------------
// cto_dp: datapath of the connection timeout table
// Holds the seconds counter, timeout register, deadline RAM and active
// bits; scans the slots for expiry and the earliest deadline, and drives
// the result register.
// ----------------------------------------------------------------------------
module cto_dp #(
  parameter int NUM_CLIENTS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  cto_pkg::cmd_t                     cmd,
  output cto_pkg::sts_t                     sts,
  input  logic [cto_pkg::MODE_W-1:0]        in_mode,
  input  logic [cto_pkg::SLOT_W-1:0]        in_client,
  input  logic                              cfg_we,
  input  logic [cto_pkg::TIMEOUT_W-1:0]     cfg_timeout,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_expired,
  output logic [cto_pkg::SLOT_W-1:0]        out_client,
  output logic                              out_pending,
  output logic [cto_pkg::DL_W-1:0]          out_next,
  output logic                              out_last
);

  localparam int IDX_W = (NUM_CLIENTS > 1) ? $clog2(NUM_CLIENTS) : 1;
  localparam int CNT_W = $clog2(NUM_CLIENTS + 1);

  // Registers
  logic [cto_pkg::DL_W-1:0]       now_r;
  logic [cto_pkg::TIMEOUT_W-1:0]  timeout_r;
  logic [NUM_CLIENTS-1:0]         active_r;
  logic [NUM_CLIENTS-1:0]         active_nxt;
  logic                           tick_r;
  logic [CNT_W-1:0]               rd_idx_r;
  logic                           eval_vld_r;
  logic [IDX_W-1:0]               eval_idx_r;
  logic                           pend_r;
  logic [cto_pkg::DL_W-1:0]       best_key_r;
  logic [cto_pkg::DL_W-1:0]       best_r;
  logic                           out_vld_r;
  logic                           out_vld_nxt;
  logic                           out_expired_r;
  logic [cto_pkg::SLOT_W-1:0]     out_client_r;
  logic                           out_pend_r;
  logic [cto_pkg::DL_W-1:0]       out_next_r;
  logic                           out_last_r;

  // Combinational
  logic                     client_ok;
  logic                     is_start;
  logic                     is_stop;
  logic                     is_tick;
  logic                     ram_we;
  logic                     ram_re;
  logic [cto_pkg::DL_W-1:0] dl;
  logic                     rd_more;
  logic                     hit_act;
  logic [cto_pkg::DL_W-1:0] diff;
  logic [cto_pkg::DL_W-1:0] key;
  logic                     expire;
  logic                     better;
  logic                     out_free;
  logic                     stall;
  logic                     advance;
  logic                     exp_load;
  logic                     close_load;

  // Decode the transaction
  assign client_ok = ({1'b0, in_client} < (cto_pkg::SLOT_W + 1)'(NUM_CLIENTS));
  assign is_start  = (in_mode == cto_pkg::MODE_START);
  assign is_stop   = (in_mode == cto_pkg::MODE_STOP);
  assign is_tick   = (in_mode == cto_pkg::MODE_TICK);

  // Deadline store
  assign ram_we = cmd.take_item && is_start && client_ok;

  cto_ram #(
    .WIDTH (cto_pkg::DL_W),
    .DEPTH (NUM_CLIENTS)
  ) u_dl_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_client[IDX_W-1:0]),
    .wdata (now_r + cto_pkg::DL_W'(timeout_r)),
    .re    (ram_re),
    .raddr (rd_idx_r[IDX_W-1:0]),
    .rdata (dl)
  );

  // Evaluate the slot whose deadline is on the read port
  assign rd_more  = (rd_idx_r < CNT_W'(NUM_CLIENTS));
  assign hit_act  = eval_vld_r && active_r[eval_idx_r];
  assign diff     = dl - (now_r + cto_pkg::DL_W'(1));
  assign expire   = tick_r && hit_act && ((diff == '0) || diff[cto_pkg::DL_W-1]);
  assign key      = (dl - now_r) ^ cto_pkg::KEY_FLIP;
  assign better   = hit_act && !expire && (!pend_r || (key < best_key_r));
  assign out_free = !out_vld_r || out_ready;
  assign stall    = expire && !out_free;
  assign advance  = cmd.scan_en && !stall;
  assign ram_re   = advance && rd_more;

  assign exp_load   = advance && expire;
  assign close_load = cmd.emit_close && out_free;

  assign sts.scan_done = !eval_vld_r && !rd_more;
  assign sts.out_free  = out_free;

  // Timeout register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r <= cto_pkg::TIMEOUT_RESET;
    end else if (cfg_we) begin
      timeout_r <= cfg_timeout;
    end
  end

  // Seconds counter and tick flag
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r  <= '0;
      tick_r <= 1'b0;
    end else if (cmd.take_item) begin
      tick_r <= is_tick;
      if (is_tick) begin
        now_r <= now_r + cto_pkg::DL_W'(1);
      end
    end
  end

  // Active bits: set on start, clear on stop or expiry
  always_comb begin
    active_nxt = active_r;
    if (cmd.take_item && client_ok && is_start) begin
      active_nxt[in_client[IDX_W-1:0]] = 1'b1;
    end
    if (cmd.take_item && client_ok && is_stop) begin
      active_nxt[in_client[IDX_W-1:0]] = 1'b0;
    end
    if (exp_load) begin
      active_nxt[eval_idx_r] = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= '0;
    end else begin
      active_r <= active_nxt;
    end
  end

  // Scan pointers: restart on a new transaction, advance unless stalled
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_idx_r   <= '0;
      eval_vld_r <= 1'b0;
      pend_r     <= 1'b0;
    end else if (cmd.take_item) begin
      rd_idx_r   <= '0;
      eval_vld_r <= 1'b0;
      pend_r     <= 1'b0;
    end else if (advance) begin
      eval_vld_r <= rd_more;
      if (rd_more) begin
        rd_idx_r <= rd_idx_r + CNT_W'(1);
      end
      if (better) begin
        pend_r <= 1'b1;
      end
    end
  end

  // Scan payload: slot under evaluation and earliest deadline so far
  always_ff @(posedge clk) begin
    if (advance) begin
      eval_idx_r <= rd_idx_r[IDX_W-1:0];
      if (better) begin
        best_key_r <= key;
        best_r     <= dl;
      end
    end
  end

  // Result register valid
  always_comb begin
    out_vld_nxt = out_vld_r;
    if (out_ready) begin
      out_vld_nxt = 1'b0;
    end
    if (exp_load || close_load) begin
      out_vld_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else begin
      out_vld_r <= out_vld_nxt;
    end
  end

  // Result register payload
  always_ff @(posedge clk) begin
    if (exp_load) begin
      out_expired_r <= 1'b1;
      out_client_r  <= cto_pkg::SLOT_W'(eval_idx_r);
      out_pend_r    <= 1'b0;
      out_next_r    <= '0;
      out_last_r    <= 1'b0;
    end else if (close_load) begin
      out_expired_r <= 1'b0;
      out_client_r  <= '0;
      out_pend_r    <= pend_r;
      out_next_r    <= pend_r ? best_r : '0;
      out_last_r    <= 1'b1;
    end
  end

  assign out_valid   = out_vld_r;
  assign out_expired = out_expired_r;
  assign out_client  = out_client_r;
  assign out_pending = out_pend_r;
  assign out_next    = out_next_r;
  assign out_last    = out_last_r;

endmodule

@@ design/connection_timeout_table.sv @@
// ----------------------------------------------------------------------------
// connection_timeout_table: per-client deadline table with one-second tick
// Start sets a slot's deadline, stop clears it, tick advances time and
// expires due slots; every transaction closes with the earliest deadline.
// ----------------------------------------------------------------------------
//
//   channel   direction   payload
//   in_ch     sink        mode, client
//   out_ch    source      expired, expired_client, pending, next_deadline, last
//   cfg_ch    sink        timeout_seconds (ready always high)
//
// The slot scan between acceptance and the closing result reads one
// deadline RAM entry per cycle while it is not stalled; an expired slot
// that finds the result register still full stalls the scan. Input is
// taken again once the closing result is loaded, while that result still
// waits in the output register. Reset is synchronous, clears time and
// active bits and sets the timeout to its reset value; the deadline RAM
// needs no clearing.
//
module connection_timeout_table #(
  parameter int NUM_CLIENTS = 32
) (
  input logic       clk,
  input logic       rst_n,
  cto_in_if.sink    in_ch,
  cto_out_if.source out_ch,
  cto_cfg_if.sink   cfg_ch
);

  logic          in_ready;
  cto_pkg::cmd_t cmd;
  cto_pkg::sts_t sts;

  // Register writes are always taken
  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = in_ready;

  // Controller
  cto_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath
  cto_dp #(
    .NUM_CLIENTS (NUM_CLIENTS)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_mode     (in_ch.mode),
    .in_client   (in_ch.client),
    .cfg_we      (cfg_ch.valid),
    .cfg_timeout (cfg_ch.timeout_seconds),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_expired (out_ch.expired),
    .out_client  (out_ch.expired_client),
    .out_pending (out_ch.pending),
    .out_next    (out_ch.next_deadline),
    .out_last    (out_ch.last)
  );

`ifndef SYNTHESIS
  // An accepted transaction keeps the input closed on the next cycle
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input ready right after a transaction was taken");

  // Expiry results carry no summary and never close a transaction
  a_expiry_shape: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.expired) |->
      (!out_ch.last && !out_ch.pending && (out_ch.next_deadline == '0)))
    else $error("expiry result carries summary fields");

  // A closing result with nothing pending reports a zero deadline
  a_close_empty: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.last && !out_ch.pending) |->
      ((out_ch.next_deadline == '0) && (out_ch.expired_client == '0)))
    else $error("closing result with nothing pending has nonzero fields");

  // Expiry results appear only while a scan is running
  a_expiry_in_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.expired && !$past(out_ch.valid && out_ch.expired)) |->
      !in_ch.ready)
    else $error("expiry result appeared outside a scan");
`endif

endmodule
